// ===== design/lrus_pkg.sv =====
// ----------------------------------------------------------------------------
// lrus_pkg: shared definitions for the LRU stack page replacement block
// Sizes, widths and the control and lookup structs passed between modules.
// ----------------------------------------------------------------------------
package lrus_pkg;

    localparam int MAX_FRAMES = 8;
    localparam int PAGE_BITS  = 16;

    localparam int FRAMES_W = 4;   // width of the frames_in_use register
    localparam int FAULT_W  = 16;  // width of the fault counter
    localparam int OUT_PAGE_W = 16;

    localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int NFR_W = $clog2(MAX_FRAMES + 1);

    localparam logic [FRAMES_W-1:0] FRAMES_RESET =
        FRAMES_W'((MAX_FRAMES > 15) ? 15 : MAX_FRAMES);
    localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

    // Control broadcast to every stack cell.
    typedef struct packed {
        logic step;   // a page reference is applied this cycle
        logic clear;  // invalidate every entry
    } lrus_ctl_t;

    // Result of one lookup along the stack.
    typedef struct packed {
        logic                 hit;
        logic                 ev_valid;
        logic [PAGE_BITS-1:0] ev_page;
    } lrus_look_t;

endpackage

// ===== design/lrus_req_if.sv =====
// ----------------------------------------------------------------------------
// lrus_req_if: page reference channel
// Valid/ready channel that carries one referenced page number per transfer.
// ----------------------------------------------------------------------------
interface lrus_req_if
    import lrus_pkg::*;
();

    logic                  valid;
    logic                  ready;
    logic [OUT_PAGE_W-1:0] page_number;

    modport source (output valid, output page_number, input ready);
    modport sink   (input valid, input page_number, output ready);

endinterface

// ===== design/lrus_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lrus_rsp_if: replacement result channel
// Valid/ready channel that carries one lookup result per transfer.
// ----------------------------------------------------------------------------
interface lrus_rsp_if
    import lrus_pkg::*;
();

    logic                  valid;
    logic                  ready;
    logic                  hit;
    logic                  evicted_valid;
    logic [OUT_PAGE_W-1:0] evicted_page;
    logic [FAULT_W-1:0]    fault_count;

    modport source (output valid, output hit, output evicted_valid,
                    output evicted_page, output fault_count, input ready);
    modport sink   (input valid, input hit, input evicted_valid,
                    input evicted_page, input fault_count, output ready);

endinterface

// ===== design/lrus_cell.sv =====
// ----------------------------------------------------------------------------
// lrus_cell: one entry of the recency stack
// Holds a page and its valid bit, compares against the reference and takes
// its upper neighbor's entry when no entry above it matched.
// ----------------------------------------------------------------------------
module lrus_cell
    import lrus_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  lrus_ctl_t            ctl,
    input  logic [PAGE_BITS-1:0] page_in,
    input  logic                 in_range,
    input  logic                 match_above,
    input  logic [PAGE_BITS-1:0] nbr_page,
    input  logic                 nbr_valid,
    output logic [PAGE_BITS-1:0] page,
    output logic                 valid,
    output logic                 match_out
);

    logic [PAGE_BITS-1:0] page_reg;
    logic                 valid_reg;
    logic                 shift;

    assign match_out = match_above | (in_range & valid_reg & (page_reg == page_in));
    // Entries down to the hit position, or the whole used stack on a miss,
    // move down by one.
    assign shift     = ctl.step & in_range & ~match_above;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift)
        begin
            valid_reg <= nbr_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            page_reg <= nbr_page;
        end
    end

    assign page  = page_reg;
    assign valid = valid_reg;

endmodule

// ===== design/lrus_stack.sv =====
// ----------------------------------------------------------------------------
// lrus_stack: chain of stack cells
// Links the cells top to bottom, forms the hit flag and picks the bottom
// entry in use as the eviction candidate.
// ----------------------------------------------------------------------------
module lrus_stack
    import lrus_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  lrus_ctl_t            ctl,
    input  logic [PAGE_BITS-1:0] page_in,
    input  logic [NFR_W-1:0]     frames,
    output lrus_look_t           look
);

    logic [PAGE_BITS-1:0] cell_page  [MAX_FRAMES];
    logic                 cell_valid [MAX_FRAMES];
    logic                 match_chain[MAX_FRAMES+1];
    logic [IDX_W-1:0]     bot_idx;
    logic                 hit;

    assign match_chain[0] = 1'b0;

    for (genvar i = 0; i < MAX_FRAMES; i++)
    begin : g_cell
        logic [PAGE_BITS-1:0] nbr_page;
        logic                 nbr_valid;

        // The top cell takes the referenced page itself.
        if (i == 0)
        begin : g_top
            assign nbr_page  = page_in;
            assign nbr_valid = 1'b1;
        end
        else
        begin : g_mid
            assign nbr_page  = cell_page[i-1];
            assign nbr_valid = cell_valid[i-1];
        end

        lrus_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .page_in    (page_in),
            .in_range   (NFR_W'(i) < frames),
            .match_above(match_chain[i]),
            .nbr_page   (nbr_page),
            .nbr_valid  (nbr_valid),
            .page       (cell_page[i]),
            .valid      (cell_valid[i]),
            .match_out  (match_chain[i+1])
        );
    end

    assign hit     = match_chain[MAX_FRAMES];
    assign bot_idx = IDX_W'(frames - NFR_W'(1));

    always_comb
    begin
        look.hit      = hit;
        look.ev_valid = ~hit & cell_valid[bot_idx];
        look.ev_page  = look.ev_valid ? cell_page[bot_idx] : '0;
    end

endmodule

// ===== design/lru_stack_page_replacement.sv =====
// ----------------------------------------------------------------------------
// lru_stack_page_replacement: LRU stack page replacement
// Result: presented in the cycle after its reference is transferred.
// Throughput: one reference per cycle while results are taken at once; the
// compare and shift along the cell chain act on acceptance. A result
// held by a stalled output keeps the input from accepting until it leaves.
// Reset: stack empty, frames_in_use = 8, fault counter zero.
// ----------------------------------------------------------------------------
module lru_stack_page_replacement
    import lrus_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    // Configuration port
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    // Data channels
    lrus_req_if.sink      req,
    lrus_rsp_if.source    rsp
);

    // Register index taken from the word address bit.
    localparam logic REG_FRAMES_IN_USE = 1'b0;

    logic [FRAMES_W-1:0]  frames_reg;
    logic [FAULT_W-1:0]   fault_reg;
    logic [FAULT_W-1:0]   fault_next;
    logic [NFR_W-1:0]     frames_act;
    logic                 cfg_wr;
    logic                 accept;
    lrus_ctl_t            ctl;
    lrus_look_t           look;

    logic                  rsp_valid_reg;
    logic                  rsp_hit_reg;
    logic                  rsp_ev_valid_reg;
    logic [OUT_PAGE_W-1:0] rsp_ev_page_reg;
    logic [FAULT_W-1:0]    rsp_fault_reg;

    // ------------------------------------------------------------------
    // Configuration. Writing frames_in_use restarts the policy with an
    // empty stack; the fault counter is kept.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_FRAMES_IN_USE);
    assign prdata = (paddr[2] == REG_FRAMES_IN_USE) ? {(32-FRAMES_W)'(0), frames_reg}
                                                   : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg <= FRAMES_RESET;
        end
        else if (cfg_wr)
        begin
            frames_reg <= pwdata[FRAMES_W-1:0];
        end
    end

    // A frame count of zero acts as one, and a count beyond the stack depth
    // acts as the full depth.
    always_comb
    begin
        priority if (frames_reg == '0)
        begin
            frames_act = NFR_W'(1);
        end
        else if (32'(frames_reg) > MAX_FRAMES)
        begin
            frames_act = NFR_W'(MAX_FRAMES);
        end
        else
        begin
            frames_act = NFR_W'(frames_reg);
        end
    end

    // ------------------------------------------------------------------
    // Reference handshake. A new reference is taken whenever the result
    // register is empty or is being emptied in the same cycle.
    // ------------------------------------------------------------------
    assign req.ready = ~rsp_valid_reg | rsp.ready;
    assign accept    = req.valid & req.ready;

    assign ctl.step  = accept;
    assign ctl.clear = cfg_wr;

    lrus_stack u_stack (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .page_in(PAGE_BITS'(req.page_number)),
        .frames (frames_act),
        .look   (look)
    );

    // The fault counter saturates at its maximum.
    assign fault_next = (!look.hit && fault_reg != FAULT_MAX) ? fault_reg + FAULT_W'(1)
                                                              : fault_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fault_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                fault_reg <= fault_next;
            end
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_hit_reg      <= look.hit;
            rsp_ev_valid_reg <= look.ev_valid;
            rsp_ev_page_reg  <= OUT_PAGE_W'(look.ev_page);
            rsp_fault_reg    <= fault_next;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.hit           = rsp_hit_reg;
    assign rsp.evicted_valid = rsp_ev_valid_reg;
    assign rsp.evicted_page  = rsp_ev_page_reg;
    assign rsp.fault_count   = rsp_fault_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp.valid)
        else $error("transfer in did not produce a result");

    a_miss_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !look.hit) |=> (rsp.fault_count != '0))
        else $error("fault counter zero after a page fault");

    a_evict_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.evicted_valid) |-> !rsp.hit)
        else $error("eviction reported on a hit");

    a_evict_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.evicted_valid) |-> (rsp.evicted_page == '0))
        else $error("evicted page not zero without an eviction");

endmodule
